>>> hdl/joystick_autocal_deadzone_scaler_top_assert.svh
// Assertion macros shared by the scaler modules.
// Each macro expects clk and rst_n in scope.
`ifndef JOYSTICK_AUTOCAL_DEADZONE_SCALER_TOP_ASSERT_SVH
`define JOYSTICK_AUTOCAL_DEADZONE_SCALER_TOP_ASSERT_SVH

// Condition must hold in the same cycle as the trigger
`define JADS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger
`define JADS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/jads_pkg.sv
package jads_pkg;

    // Sample width default and the narrowest bound register width
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int BOUND_MIN_W     = 12;

    // Configuration register width and reset values
    localparam int REG_W              = 15;
    localparam int NORM_RANGE_RESET   = 256;
    localparam int DEADZONE_RESET     = 26;

    // Calibration bound reset values
    localparam int X_LOW_RESET  = 10;
    localparam int X_HIGH_RESET = 1600;
    localparam int Y_LOW_RESET  = 10;
    localparam int Y_HIGH_RESET = 1630;

    // Result width and divider length (quotient never exceeds norm_range)
    localparam int OUT_W     = 16;
    localparam int DIV_STEPS = REG_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_NORM_RANGE = 1'b0;
    localparam logic REG_DEADZONE   = 1'b1;

    // Shared multiplier operand selects
    localparam logic [1:0] MUL_MAG  = 2'd0;  // norm_range * |t|
    localparam logic [1:0] MUL_DZ   = 2'd1;  // deadzone * span
    localparam logic [1:0] MUL_NUM  = 2'd2;  // norm_range * excess
    localparam logic [1:0] MUL_DEN  = 2'd3;  // (norm_range - deadzone) * span

    typedef struct packed {
        logic       load_in;
        logic       upd_bound;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       check;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic zero;
    } dp_status_t;

endpackage

>>> hdl/jads_ctrl.sv
module jads_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output jads_pkg::dp_cmd_t    cmd,
    input  jads_pkg::dp_status_t status
);
    import jads_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_BOUND    = 4'd1;
    localparam logic [3:0] ST_MUL_MAG  = 4'd2;
    localparam logic [3:0] ST_MUL_DZ   = 4'd3;
    localparam logic [3:0] ST_CHECK    = 4'd4;
    localparam logic [3:0] ST_MUL_NUM  = 4'd5;
    localparam logic [3:0] ST_MUL_DEN  = 4'd6;
    localparam logic [3:0] ST_DIV_INIT = 4'd7;
    localparam logic [3:0] ST_DIV      = 4'd8;
    localparam logic [3:0] ST_DONE     = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // Sequence one item through the datapath
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_BOUND;
                end
            end
            ST_BOUND:
            begin
                cmd.upd_bound = 1'b1;
                state_next    = ST_MUL_MAG;
            end
            ST_MUL_MAG:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MAG;
                state_next  = ST_MUL_DZ;
            end
            ST_MUL_DZ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DZ;
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = status.zero ? ST_DONE : ST_MUL_NUM;
            end
            ST_MUL_NUM:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_NUM;
                state_next  = ST_MUL_DEN;
            end
            ST_MUL_DEN:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DEN;
                state_next  = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Wait until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Track the output register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`include "joystick_autocal_deadzone_scaler_top_assert.svh"

    `JADS_ASSERT_NEXT(a_start_bound, s_tvalid && s_tready, state_reg == ST_BOUND, "accepted item did not start")
    `JADS_ASSERT_IMPLY(a_cnt_range, state_reg == ST_DIV, cnt_reg <= CNT_W'(DIV_STEPS - 1), "divider count overran")
    `JADS_ASSERT_IMPLY(a_no_overwrite, cmd.out_load, !out_valid_reg || m_tready, "pending result overwritten")

endmodule

>>> hdl/jads_dp.sv
module jads_dp #(
    parameter int SAMPLE_BITS = jads_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  jads_pkg::dp_cmd_t                 cmd,
    output jads_pkg::dp_status_t              status,
    input  logic                              in_axis,
    input  logic [SAMPLE_BITS-1:0]            in_sample,
    input  logic [jads_pkg::REG_W-1:0]        norm_range,
    input  logic [jads_pkg::REG_W-1:0]        deadzone,
    output logic                              out_axis,
    output logic signed [jads_pkg::OUT_W-1:0] out_value
);
    import jads_pkg::*;

    localparam int BW = (SAMPLE_BITS > BOUND_MIN_W) ? SAMPLE_BITS : BOUND_MIN_W;
    localparam int MW = REG_W + BW;
    localparam int PW = REG_W + MW;

    logic [BW-1:0]    x_lo_reg, x_hi_reg, y_lo_reg, y_hi_reg;
    logic [BW-1:0]    v_reg;
    logic             axis_reg;
    logic [BW-1:0]    span_reg, tmag_reg;
    logic             tneg_reg;
    logic [MW-1:0]    m_reg, dz_reg, diff_reg, den_reg, rem_reg;
    logic [PW-1:0]    num_reg;
    logic [REG_W-1:0] low_reg;
    logic             out_axis_reg;
    logic [OUT_W-1:0] out_value_reg;

    logic [BW-1:0]    lo_cur, hi_cur, lo_new, hi_new, below, above;
    logic [REG_W-1:0] mul_a;
    logic [MW-1:0]    mul_b;
    logic [PW-1:0]    mul_p;
    logic [MW:0]      trial, trial_sub;
    logic             trial_ge;
    logic             neg_final;
    logic [OUT_W-1:0] mag_ext;

    // Widen the selected axis bounds and split the offset into sign and size
    always_comb
    begin
        lo_cur = axis_reg ? y_lo_reg : x_lo_reg;
        hi_cur = axis_reg ? y_hi_reg : x_hi_reg;
        lo_new = (v_reg < lo_cur) ? v_reg : lo_cur;
        hi_new = (v_reg > hi_cur) ? v_reg : hi_cur;
        below  = v_reg - lo_new;
        above  = hi_new - v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_lo_reg <= BW'(X_LOW_RESET);
            x_hi_reg <= BW'(X_HIGH_RESET);
            y_lo_reg <= BW'(Y_LOW_RESET);
            y_hi_reg <= BW'(Y_HIGH_RESET);
        end
        else if (cmd.upd_bound)
        begin
            if (axis_reg)
            begin
                y_lo_reg <= lo_new;
                y_hi_reg <= hi_new;
            end
            else
            begin
                x_lo_reg <= lo_new;
                x_hi_reg <= hi_new;
            end
        end
    end

    // Shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_MAG:
            begin
                mul_a = norm_range;
                mul_b = MW'(tmag_reg);
            end
            MUL_DZ:
            begin
                mul_a = deadzone;
                mul_b = MW'(span_reg);
            end
            MUL_NUM:
            begin
                mul_a = norm_range;
                mul_b = diff_reg;
            end
            MUL_DEN:
            begin
                mul_a = norm_range - deadzone;
                mul_b = MW'(span_reg);
            end
            default:
            begin
                mul_a = norm_range;
                mul_b = MW'(tmag_reg);
            end
        endcase
        mul_p = PW'(mul_a) * PW'(mul_b);
    end

    // Zero result: deadzone covers range, empty span, or inside deadzone
    assign status.zero = (deadzone >= norm_range) || (span_reg == '0) || (m_reg < dz_reg);

    // One restoring division step
    always_comb
    begin
        trial     = {rem_reg, low_reg[REG_W-1]};
        trial_ge  = (trial >= {1'b0, den_reg});
        trial_sub = trial - {1'b0, den_reg};
    end

    // Apply sign, flip for Y
    always_comb
    begin
        neg_final = tneg_reg ^ axis_reg;
        mag_ext   = {1'b0, low_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            axis_reg <= in_axis;
            v_reg    <= BW'(in_sample);
        end
        if (cmd.upd_bound)
        begin
            span_reg <= hi_new - lo_new;
            tneg_reg <= (below < above);
            tmag_reg <= (below < above) ? (above - below) : (below - above);
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                MUL_MAG:  m_reg   <= mul_p[MW-1:0];
                MUL_DZ:   dz_reg  <= mul_p[MW-1:0];
                MUL_NUM:  num_reg <= mul_p;
                MUL_DEN:  den_reg <= mul_p[MW-1:0];
                default:  m_reg   <= mul_p[MW-1:0];
            endcase
        end
        if (cmd.check)
        begin
            diff_reg <= m_reg - dz_reg;
            if (status.zero)
            begin
                low_reg <= '0;
            end
        end
        if (cmd.div_init)
        begin
            rem_reg <= num_reg[PW-1:REG_W];
            low_reg <= num_reg[REG_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_sub[MW-1:0] : trial[MW-1:0];
            low_reg <= {low_reg[REG_W-2:0], trial_ge};
        end
        if (cmd.out_load)
        begin
            out_axis_reg  <= axis_reg;
            out_value_reg <= neg_final ? (OUT_W'(0) - mag_ext) : mag_ext;
        end
    end

    assign out_axis  = out_axis_reg;
    assign out_value = out_value_reg;

`include "joystick_autocal_deadzone_scaler_top_assert.svh"

    `JADS_ASSERT_IMPLY(a_x_order, 1'b1, x_lo_reg <= x_hi_reg, "X bounds crossed")
    `JADS_ASSERT_IMPLY(a_y_order, 1'b1, y_lo_reg <= y_hi_reg, "Y bounds crossed")
    `JADS_ASSERT_IMPLY(a_rem_below, cmd.div_step, rem_reg < den_reg, "divider remainder not below divisor")

endmodule

>>> hdl/joystick_autocal_deadzone_scaler_top.sv
// Joystick axis auto-calibration with deadzone.
// Input stream: s_tdata carries raw_sample, s_tuser the axis (0 = X, 1 = Y).
// Output stream: m_tdata carries the signed Q8.8 position, m_tuser the axis.
// Each input transfer updates that axis's running min/max, maps the sample to
// -norm_range..+norm_range, zeroes it inside the deadzone, rescales the rest
// and negates Y. norm_range and deadzone are set over the APB port
// (byte address 0 and 4); the user must set them only while the block is
// idle, since the block itself does not enforce this.
// Results come from the 15-step restoring divider behind a shared multiplier;
// when the result is known to be zero (inside deadzone, empty span, deadzone
// not below range) the rescale multiplies and the divider are skipped.
// One item is in flight at a time; the next input is accepted only once the
// result has entered the output register and the controller is back in idle.
// A stalled receiver holds the result in the output register; the block keeps
// accepting and working on the next item and waits only before overwriting it.
// Reset restores the calibration bounds (X 10..1600, Y 10..1630) and the
// register defaults (norm_range 256, deadzone 26) and empties the output.
module joystick_autocal_deadzone_scaler_top #(
    parameter int SAMPLE_BITS = jads_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    // APB configuration
    input  logic                                                psel,
    input  logic                                                penable,
    input  logic                                                pwrite,
    input  logic [jads_pkg::APB_ADDR_W-1:0]                     paddr,
    input  logic [jads_pkg::APB_DATA_W-1:0]                     pwdata,
    output logic [jads_pkg::APB_DATA_W-1:0]                     prdata,
    output logic                                                pready,
    // Input stream
    input  logic                                                s_tvalid,
    output logic                                                s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]            s_tdata,  // raw_sample
    input  logic [0:0]                                          s_tuser,  // axis
    // Output stream
    output logic                                                m_tvalid,
    input  logic                                                m_tready,
    output logic [jads_pkg::OUT_W-1:0]                          m_tdata,  // scaled_value
    output logic [0:0]                                          m_tuser   // out_axis
);
    import jads_pkg::*;

    logic [REG_W-1:0]  norm_range_reg, deadzone_reg;
    logic              cfg_write;
    dp_cmd_t           cmd;
    dp_status_t        status;
    logic              out_axis;
    logic signed [OUT_W-1:0] out_value;

    // APB register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_range_reg <= REG_W'(NORM_RANGE_RESET);
            deadzone_reg   <= REG_W'(DEADZONE_RESET);
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_NORM_RANGE: norm_range_reg <= pwdata[REG_W-1:0];
                REG_DEADZONE:   deadzone_reg   <= pwdata[REG_W-1:0];
                default:        norm_range_reg <= norm_range_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_NORM_RANGE: prdata = APB_DATA_W'(norm_range_reg);
            REG_DEADZONE:   prdata = APB_DATA_W'(deadzone_reg);
            default:        prdata = '0;
        endcase
    end

    jads_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    jads_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_axis    (s_tuser[0]),
        .in_sample  (s_tdata[SAMPLE_BITS-1:0]),
        .norm_range (norm_range_reg),
        .deadzone   (deadzone_reg),
        .out_axis   (out_axis),
        .out_value  (out_value)
    );

    assign m_tdata    = out_value;
    assign m_tuser[0] = out_axis;

endmodule

>>> test/jads_position_check.sv
`timescale 1ns / 1ps

// Watches the APB port and both streams of the scaler, predicts the position
// for every accepted sample and compares it with the result transfers.
module jads_position_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [jads_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [jads_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic                                pready,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [15:0]                         s_tdata,  // raw_sample, zero padded
    input  logic [0:0]                          s_tuser,  // axis
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [jads_pkg::OUT_W-1:0]          m_tdata,  // scaled_value
    input  logic [0:0]                          m_tuser,  // out_axis
    output int                                  outstanding,
    output int                                  mismatches
);

    typedef struct packed {
        logic               axis;
        logic signed [15:0] value;
    } position_t;

    // Mirror of the configuration and of the running calibration bounds
    logic [jads_pkg::REG_W-1:0] norm_range;
    logic [jads_pkg::REG_W-1:0] deadzone;
    logic [11:0]                lo_bound [2];
    logic [11:0]                hi_bound [2];

    position_t expected_q [$];
    int        mismatch_count = 0;

    // Exact integer mapping of a sample to the rescaled, signed position
    function automatic logic signed [15:0] scaled_position(
        input logic [11:0] v,
        input logic [11:0] lo,
        input logic [11:0] hi,
        input logic        flip
    );
        longint     rr;
        longint     dd;
        longint     sp;
        longint     dv;
        longint     num;
        longint     mag;
        longint     quot;
        logic       negative;
        logic [15:0] q16;
        rr       = norm_range;
        dd       = deadzone;
        negative = 1'b0;
        quot     = 0;
        if (dd < rr && hi > lo)
        begin
            sp       = hi - lo;
            dv       = v - lo;
            // position is num / sp
            num      = 2 * rr * dv - rr * sp;
            negative = (num < 0);
            mag      = negative ? -num : num;
            if (mag >= dd * sp)
                quot = ((mag - dd * sp) * rr) / (sp * (rr - dd));
            if (quot > 32767)
                quot = 32767;
        end
        if (flip)
            negative = !negative;
        q16 = quot[15:0];
        return negative ? -q16 : q16;
    endfunction

    task automatic report_mismatch(input string field, input int exp_val, input int act_val);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, exp_val, act_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        position_t   got;
        position_t   want;
        logic        ax;
        logic [11:0] v;
        if (!rst_n)
        begin
            norm_range  = jads_pkg::REG_W'(jads_pkg::NORM_RANGE_RESET);
            deadzone    = jads_pkg::REG_W'(jads_pkg::DEADZONE_RESET);
            lo_bound[0] = 12'(jads_pkg::X_LOW_RESET);
            hi_bound[0] = 12'(jads_pkg::X_HIGH_RESET);
            lo_bound[1] = 12'(jads_pkg::Y_LOW_RESET);
            hi_bound[1] = 12'(jads_pkg::Y_HIGH_RESET);
            expected_q.delete();
            outstanding <= 0;
            mismatches  <= mismatch_count;
        end
        else
        begin
            // Mirror register writes, upper bits dropped
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == jads_pkg::REG_NORM_RANGE)
                    norm_range = pwdata[jads_pkg::REG_W-1:0];
                else if (paddr[2] == jads_pkg::REG_DEADZONE)
                    deadzone = pwdata[jads_pkg::REG_W-1:0];
            end

            // Compare a result transfer with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got.axis  = m_tuser[0];
                got.value = m_tdata;
                if (expected_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with nothing pending: axis %0d, value %0d",
                                 $time, got.axis, got.value);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.axis !== want.axis)
                        report_mismatch("out_axis", want.axis, got.axis);
                    if (got.value !== want.value)
                        report_mismatch("scaled_value", want.value, got.value);
                end
            end

            // Widen the bounds and predict for a sample transfer
            if (s_tvalid && s_tready)
            begin
                ax = s_tuser[0];
                v  = s_tdata[11:0];
                if (v < lo_bound[ax])
                    lo_bound[ax] = v;
                if (v > hi_bound[ax])
                    hi_bound[ax] = v;
                want.axis  = ax;
                want.value = scaled_position(v, lo_bound[ax], hi_bound[ax], ax);
                expected_q.push_back(want);
            end

            outstanding <= expected_q.size();
            mismatches  <= mismatch_count;
        end
    end

endmodule

>>> test/joystick_autocal_deadzone_scaler_top_tb.sv
`timescale 1ns / 1ps

module joystick_autocal_deadzone_scaler_top_tb;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    logic clk;
    logic rst_n = 1'b0;

    logic                              psel    = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite  = 1'b0;
    logic [jads_pkg::APB_ADDR_W-1:0]   paddr   = '0;
    logic [jads_pkg::APB_DATA_W-1:0]   pwdata  = '0;
    logic [jads_pkg::APB_DATA_W-1:0]   prdata;
    logic                              pready;

    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [15:0]                       s_tdata  = '0;  // raw_sample, zero padded
    logic [0:0]                        s_tuser  = '0;  // axis
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [jads_pkg::OUT_W-1:0]        m_tdata;        // scaled_value
    logic [0:0]                        m_tuser;        // out_axis

    int outstanding;
    int mismatches;

    // Sender pacing and the sample span seen so far, per axis
    int burst_left = 1;
    int seen_lo [2];
    int seen_hi [2];

    // Receiver stall pattern
    int stall_mode = 0;
    int stall_left = 0;

    joystick_autocal_deadzone_scaler_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    jads_position_check u_position_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hang guard
    initial
    begin
        #10_000_000;
        $display("** joystick_autocal_deadzone_scaler_top: FAILED **");
        $finish;
    end

    // Receiver: segments of always ready, coin flip, or mostly stalled
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(1, 80);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Offer one sample, hold until the transfer, then keep or break the burst
    task automatic send_sample(input logic ax, input logic [11:0] raw);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= ax;
        s_tdata  <= {4'b0000, raw};
        do @(posedge clk); while (!s_tready);
        if (raw < seen_lo[ax])
            seen_lo[ax] = raw;
        if (raw > seen_hi[ax])
            seen_hi[ax] = raw;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Drop valid and hold until every predicted result has been taken
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [14:0] value, input bit junk_upper);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= junk_upper ? (($urandom() & 32'hFFFF_8000) | value) : {17'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [14:0] range_q88, input logic [14:0] dz_q88,
                              input bit junk_upper);
        write_reg(jads_pkg::REG_NORM_RANGE, range_q88, junk_upper);
        write_reg(jads_pkg::REG_DEADZONE, dz_q88, junk_upper);
    endtask

    // Mostly inside the span seen so far, sometimes nudging it wider
    function automatic logic [11:0] pick_sample(input logic ax, input bit full_swing);
        int lo;
        int hi;
        int pick;
        int step;
        lo   = seen_lo[ax];
        hi   = seen_hi[ax];
        pick = $urandom_range(0, 99);
        step = $urandom_range(1, 40);
        if (full_swing && pick < 10)
            return 12'($urandom_range(0, 4095));
        if (pick < 25)
        begin
            if ($urandom_range(0, 1))
                return (lo - step < 0) ? 12'd0 : 12'(lo - step);
            return (hi + step > 4095) ? 12'd4095 : 12'(hi + step);
        end
        if (pick < 32)
        begin
            case ($urandom_range(0, 2))
                0:       return 12'(lo);
                1:       return 12'(hi);
                default: return 12'((lo + hi) / 2);
            endcase
        end
        return 12'($urandom_range(lo, hi));
    endfunction

    task automatic random_phase(input int count, input bit full_swing, input bit hold_midway);
        logic ax;
        for (int i = 0; i < count; i++)
        begin
            if (hold_midway && i == count / 2)
                wait_idle();
            ax = 1'($urandom_range(0, 1));
            send_sample(ax, pick_sample(ax, full_swing));
        end
        wait_idle();
    endtask

    initial
    begin
        logic [14:0] rand_range;
        logic [14:0] rand_dz;
        seen_lo[0] = jads_pkg::X_LOW_RESET;
        seen_hi[0] = jads_pkg::X_HIGH_RESET;
        seen_lo[1] = jads_pkg::Y_LOW_RESET;
        seen_hi[1] = jads_pkg::Y_HIGH_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: bounds, centers, both signs
        send_sample(AXIS_X, 12'd10);
        send_sample(AXIS_X, 12'd1600);
        send_sample(AXIS_X, 12'd805);
        send_sample(AXIS_Y, 12'd10);
        send_sample(AXIS_Y, 12'd1630);
        send_sample(AXIS_Y, 12'd820);
        send_sample(AXIS_X, 12'd300);
        send_sample(AXIS_Y, 12'd1500);
        wait_idle();

        // Position lands exactly on the deadzone edge at 1000, then just off it
        set_config(15'd848, 15'd208, 1'b0);
        send_sample(AXIS_X, 12'd1000);
        send_sample(AXIS_X, 12'd1001);
        send_sample(AXIS_X, 12'd999);
        send_sample(AXIS_X, 12'd19);
        wait_idle();

        // Full scale, no deadzone, sample extremes
        set_config(15'h7FFF, 15'd0, 1'b0);
        send_sample(AXIS_X, 12'd0);
        send_sample(AXIS_X, 12'hFFF);
        send_sample(AXIS_X, 12'd2047);
        send_sample(AXIS_X, 12'd2048);
        send_sample(AXIS_Y, 12'd820);
        wait_idle();

        // Deadzone equal to range
        set_config(15'h7FFF, 15'h7FFF, 1'b0);
        send_sample(AXIS_X, 12'd100);
        wait_idle();

        // Smallest range
        set_config(15'd1, 15'd0, 1'b0);
        send_sample(AXIS_X, 12'd3000);
        send_sample(AXIS_Y, 12'd1629);
        wait_idle();

        // Deadzone above range, written with junk upper bits
        set_config(15'd300, 15'd400, 1'b1);
        send_sample(AXIS_X, 12'd3500);
        wait_idle();

        // Random phases over several settings
        set_config(15'd256, 15'd26, 1'b0);
        random_phase(160, 1'b0, 1'b0);
        set_config(15'h7FFF, 15'd0, 1'b1);
        random_phase(160, 1'b0, 1'b1);
        set_config(15'd1, 15'd0, 1'b0);
        random_phase(150, 1'b0, 1'b0);
        set_config(15'd1000, 15'd999, 1'b1);
        random_phase(150, 1'b0, 1'b0);
        set_config(15'd500, 15'd700, 1'b0);
        random_phase(120, 1'b0, 1'b0);
        rand_range = 15'($urandom_range(2, 32767));
        rand_dz    = 15'($urandom_range(0, rand_range - 1));
        set_config(rand_range, rand_dz, 1'b1);
        random_phase(180, 1'b1, 1'b0);
        set_config(15'h7FFF, 15'd16000, 1'b0);
        random_phase(160, 1'b1, 1'b0);

        // Let any stray result show up
        repeat (40) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("** joystick_autocal_deadzone_scaler_top: PASSED **");
        else
            $display("** joystick_autocal_deadzone_scaler_top: FAILED **");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/jads_pkg.sv
hdl/jads_ctrl.sv
hdl/jads_dp.sv
hdl/joystick_autocal_deadzone_scaler_top.sv
test/jads_position_check.sv
test/joystick_autocal_deadzone_scaler_top_tb.sv
